// ===== rtl/assert_macros.svh =====
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is high
`define GWM_ASSERT_IMP(lbl, clk, rst, pre, post, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) else $error(msg);

// next-cycle implication, disabled while reset is high
`define GWM_ASSERT_NXT(lbl, clk, rst, pre, post, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);

`endif

// ===== rtl/gwm_pkg.sv =====
// types and constants of the glob wildcard matcher
package gwm_pkg;

   // item kinds carried in tuser
   localparam logic [1:0] KIND_CLEAR   = 2'd0;
   localparam logic [1:0] KIND_APPEND  = 2'd1;
   localparam logic [1:0] KIND_SUBJECT = 2'd2;
   localparam logic [1:0] KIND_END     = 2'd3;

   // pattern characters
   localparam logic [7:0] CH_CARET = 8'h5E;
   localparam logic [7:0] CH_OPEN  = 8'h5B;
   localparam logic [7:0] CH_QUERY = 8'h3F;
   localparam logic [7:0] CH_STAR  = 8'h2A;
   localparam logic [7:0] CH_DASH  = 8'h2D;
   localparam logic [7:0] CH_CLOSE = 8'h5D;

   // class parser states
   typedef enum logic [3:0] {
      PS_TOP   = 4'b0001,
      PS_OPEN  = 4'b0010,
      PS_CARET = 4'b0100,
      PS_BODY  = 4'b1000
   } gwm_ps_type;

   // role of one stored pattern byte inside a bracket class
   typedef struct packed {
      logic caret;
      logic body;
      logic start;
      logic skipnext;
      logic close;
      logic neg;
   } gwm_flags_type;

   // write controls for one cell
   typedef struct packed {
      logic          wr_en;
      logic [7:0]    wr_byte;
      gwm_flags_type wr_flags;
      logic          fin_en;
      logic          fin_start;
      logic          skp_en;
   } gwm_cell_ctl_type;

   // per-cell status toward the chains
   typedef struct packed {
      logic star;
      logic open;
      logic adv;
      logic cls_prop;
      logic body;
      logic hit;
      logic close;
      logic neg;
   } gwm_cell_out_type;

endpackage

// ===== rtl/gwm_cell.sv =====
// one pattern cell: stored byte, class role and local match logic
module gwm_cell (
   input  logic                      clock,
   input  gwm_pkg::gwm_cell_ctl_type ctl,
   input  logic [7:0]                subj_byte,
   input  logic [7:0]                hi_byte,
   output logic [7:0]                pat_byte,
   output gwm_pkg::gwm_cell_out_type st
);

   logic [7:0]             byte_ff, byte_in;
   gwm_pkg::gwm_flags_type flags_ff, flags_in;

   // load a new byte or finish its class role later
   always_comb begin
      byte_in  = byte_ff;
      flags_in = flags_ff;
      if (ctl.wr_en) begin
         byte_in  = ctl.wr_byte;
         flags_in = ctl.wr_flags;
      end else begin
         if (ctl.fin_en) begin
            flags_in.start = ctl.fin_start;
         end
         if (ctl.skp_en) begin
            flags_in.skipnext = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      byte_ff  <= byte_in;
      flags_ff <= flags_in;
   end

   // local match terms
   always_comb begin
      st.star     = (byte_ff == gwm_pkg::CH_STAR);
      st.open     = (byte_ff == gwm_pkg::CH_OPEN);
      st.adv      = (byte_ff == gwm_pkg::CH_QUERY) ||
                    ((byte_ff == subj_byte) && (byte_ff != gwm_pkg::CH_STAR) &&
                     (byte_ff != gwm_pkg::CH_OPEN));
      st.cls_prop = flags_ff.caret | flags_ff.body;
      st.body     = flags_ff.body;
      st.hit      = flags_ff.start &&
                    ((byte_ff == subj_byte) ||
                     (flags_ff.skipnext && (byte_ff <= subj_byte) && (subj_byte <= hi_byte)));
      st.close    = flags_ff.close;
      st.neg      = flags_ff.neg;
   end

   assign pat_byte = byte_ff;

endmodule

// ===== rtl/gwm_chain.sv =====
// carry-style prefix chain: carry into each bit from generate and propagate
module gwm_chain #(
   parameter int W = 64
) (
   input  logic [W-1:0] gen,
   input  logic [W-1:0] prop,
   output logic [W-1:0] cin
);

   logic [W-1:0] opa, opb, sum;

   // a carry enters bit k+1 when bit k generates, or propagates an incoming one
   assign opa = gen;
   assign opb = prop | gen;
   assign sum = opa + opb;
   assign cin = sum ^ opa ^ opb;

endmodule

// ===== rtl/glob_wildcard_matcher.sv =====
// Glob wildcard matcher: a pattern of literals, '?', '*' and bracket classes is loaded a
// byte per beat, then subject bytes run through a row of PAT_LEN cells that hold the
// live pattern positions. Every kind of item is taken at one beat per cycle with no
// stall of its own; the block only waits when its result register is full and not
// taken. An end-of-subject beat gives its result in the cycle after acceptance. The cycle
// time is set by the star closure chain across all positions feeding the two class
// chains and the position update. No clearing pass runs after reset.
module glob_wildcard_matcher #(
   parameter int PAT_LEN = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [7:0] pattern_byte, [15:8] subject_byte
   input  logic [1:0]  req_tuser,   // [1:0] kind
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata    // [0] matched, [1] pattern_too_long, [7:2] zero
);

   localparam int N  = PAT_LEN;
   localparam int LW = $clog2(PAT_LEN + 1);

   logic [LW-1:0]       len_ff, len_in;
   logic                ovf_ff, ovf_in;
   logic [N:0]          act_ff, act_in;
   gwm_pkg::gwm_ps_type ps_ff, ps_in;
   logic                neg_ff, neg_in;
   logic                pend_ff, pend_in;
   logic                rsp_vld_ff, rsp_vld_in;
   logic [1:0]          rsp_dat_ff, rsp_dat_in;

   logic       acc;
   logic [1:0] kind;
   logic [7:0] pb, sb;
   logic       store, skip;
   gwm_pkg::gwm_flags_type new_flags;

   logic [7:0]                 cell_byte [N];
   gwm_pkg::gwm_cell_out_type  cst [N];
   logic [N-1:0] valid, sv, aa_gen, aa_prop, hit_gen, hit_prop, aa_c, hit_c, adv, fire;
   logic [N:0]   cl_gen, cl_prop, cl_c, cl, nxt;
   logic         m;

   // input beat decode
   assign req_tready = !rsp_vld_ff || rsp_tready;
   assign acc        = req_tvalid && req_tready;
   assign kind       = req_tuser;
   assign pb         = req_tdata[7:0];
   assign sb         = req_tdata[15:8];
   assign store      = acc && (kind == gwm_pkg::KIND_APPEND) && (pb != 8'd0) &&
                       (int'(len_ff) < N);
   assign skip       = pend_ff && (pb != gwm_pkg::CH_CLOSE);

   // class parser: role of the byte being stored
   always_comb begin
      new_flags = '0;
      ps_in     = ps_ff;
      neg_in    = neg_ff;
      pend_in   = pend_ff;
      unique case (ps_ff)
         gwm_pkg::PS_TOP: begin
            if (pb == gwm_pkg::CH_OPEN) begin
               ps_in  = gwm_pkg::PS_OPEN;
               neg_in = 1'b0;
            end
         end
         gwm_pkg::PS_OPEN: begin
            if (pb == gwm_pkg::CH_CARET) begin
               new_flags.caret = 1'b1;
               neg_in          = 1'b1;
               ps_in           = gwm_pkg::PS_CARET;
            end else begin
               new_flags.body  = 1'b1;
               new_flags.start = 1'b1;
               pend_in         = 1'b0;
               ps_in           = gwm_pkg::PS_BODY;
            end
         end
         gwm_pkg::PS_CARET: begin
            new_flags.body  = 1'b1;
            new_flags.start = 1'b1;
            pend_in         = 1'b0;
            ps_in           = gwm_pkg::PS_BODY;
         end
         gwm_pkg::PS_BODY: begin
            if (pb == gwm_pkg::CH_CLOSE) begin
               new_flags.close = 1'b1;
               new_flags.neg   = neg_ff;
               ps_in           = gwm_pkg::PS_TOP;
            end else begin
               new_flags.body = 1'b1;
               pend_in        = (pb == gwm_pkg::CH_DASH) && !skip;
            end
         end
         default: begin
            ps_in = gwm_pkg::PS_TOP;
         end
      endcase
   end

   // row of pattern cells
   for (genvar k = 0; k < N; k++) begin : g_cell
      gwm_pkg::gwm_cell_ctl_type ctl;
      logic [7:0]                hi;

      always_comb begin
         ctl.wr_en     = store && (int'(len_ff) == k);
         ctl.wr_byte   = pb;
         ctl.wr_flags  = new_flags;
         ctl.fin_en    = store && (ps_ff == gwm_pkg::PS_BODY) && (int'(len_ff) == k + 1);
         ctl.fin_start = !skip;
         ctl.skp_en    = store && (ps_ff == gwm_pkg::PS_BODY) && skip &&
                         (int'(len_ff) == k + 2);
      end

      if (k + 2 < N) begin : g_hi
         assign hi = cell_byte[k+2];
      end else begin : g_nohi
         assign hi = 8'd0;
      end

      gwm_cell u_cell (
         .clock     (clock),
         .ctl       (ctl),
         .subj_byte (sb),
         .hi_byte   (hi),
         .pat_byte  (cell_byte[k]),
         .st        (cst[k])
      );

      assign valid[k]    = int'(len_ff) > k;
      assign sv[k]       = valid[k] && cst[k].star;
      assign aa_prop[k]  = valid[k] && cst[k].cls_prop;
      assign hit_gen[k]  = valid[k] && cst[k].body && cst[k].hit;
      assign hit_prop[k] = valid[k] && cst[k].body;
      assign aa_gen[k]   = valid[k] && cl[k] && cst[k].open;
      assign adv[k]      = valid[k] && cl[k] && cst[k].adv;
      assign fire[k]     = valid[k] && cst[k].close && aa_c[k] && (hit_c[k] ^ cst[k].neg);
   end

   // star closure of the live set
   assign cl_prop = {1'b0, sv};
   assign cl_gen  = act_ff & cl_prop;

   gwm_chain #(.W(N + 1)) u_star (
      .gen  (cl_gen),
      .prop (cl_prop),
      .cin  (cl_c)
   );

   assign cl = act_ff | cl_c;

   // live open bracket carried to its closing bracket
   gwm_chain #(.W(N)) u_open (
      .gen  (aa_gen),
      .prop (aa_prop),
      .cin  (aa_c)
   );

   // any member hit carried to the closing bracket
   gwm_chain #(.W(N)) u_hit (
      .gen  (hit_gen),
      .prop (hit_prop),
      .cin  (hit_c)
   );

   // next live set: stars stay, matches step to the neighbor, classes jump past ']'
   assign nxt[0] = cl[0] && sv[0];
   for (genvar i = 1; i < N; i++) begin : g_nxt
      assign nxt[i] = (cl[i] && sv[i]) || adv[i-1] || fire[i-1];
   end
   assign nxt[N] = adv[N-1] || fire[N-1];

   assign m = cl[len_ff] && !ovf_ff;

   // pattern and tracking state
   always_comb begin
      len_in     = len_ff;
      ovf_in     = ovf_ff;
      act_in     = act_ff;
      rsp_vld_in = rsp_vld_ff && !rsp_tready;
      rsp_dat_in = rsp_dat_ff;
      if (acc) begin
         unique case (kind)
            gwm_pkg::KIND_CLEAR: begin
               len_in = '0;
               ovf_in = 1'b0;
               act_in = (N + 1)'(1);
            end
            gwm_pkg::KIND_APPEND: begin
               if (store) begin
                  len_in = len_ff + LW'(1);
               end else if (pb != 8'd0) begin
                  ovf_in = 1'b1;
               end
               act_in = (N + 1)'(1);
            end
            gwm_pkg::KIND_SUBJECT: begin
               act_in = nxt;
            end
            gwm_pkg::KIND_END: begin
               act_in     = (N + 1)'(1);
               rsp_vld_in = 1'b1;
               rsp_dat_in = {ovf_ff, m};
            end
            default: begin
               act_in = act_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff     <= '0;
         ovf_ff     <= 1'b0;
         act_ff     <= (N + 1)'(1);
         ps_ff      <= gwm_pkg::PS_TOP;
         neg_ff     <= 1'b0;
         pend_ff    <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else begin
         len_ff     <= len_in;
         ovf_ff     <= ovf_in;
         act_ff     <= act_in;
         rsp_vld_ff <= rsp_vld_in;
         if (acc && (kind == gwm_pkg::KIND_CLEAR)) begin
            ps_ff   <= gwm_pkg::PS_TOP;
            neg_ff  <= 1'b0;
            pend_ff <= 1'b0;
         end else if (store) begin
            ps_ff   <= ps_in;
            neg_ff  <= neg_in;
            pend_ff <= pend_in;
         end
      end
   end

   // result register
   always_ff @(posedge clock) begin
      rsp_dat_ff <= rsp_dat_in;
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = {6'd0, rsp_dat_ff};

endmodule

// ===== rtl/gwm_checker.sv =====
// port-level checks of the glob wildcard matcher and their binding
`include "assert_macros.svh"

module gwm_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic [1:0]  req_tuser,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [7:0]  rsp_tdata
);

   logic end_beat;

   assign end_beat = req_tvalid && req_tready && (req_tuser == gwm_pkg::KIND_END);

   // an end-of-subject beat always yields a result next cycle
   `GWM_ASSERT_NXT(a_end_gives_rsp, clock, reset, end_beat, rsp_tvalid, "no result after end beat")

   // a new result only follows an end-of-subject beat
   `GWM_ASSERT_IMP(a_rsp_from_end, clock, reset, $rose(rsp_tvalid), $past(end_beat), "result without end beat")

   // an overlong pattern never reports a match
   `GWM_ASSERT_IMP(a_long_no_match, clock, reset, rsp_tvalid && rsp_tdata[1], !rsp_tdata[0], "match with overlong pattern")

   // stalled result beat holds
   `GWM_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata), "stalled result changed")

endmodule

bind glob_wildcard_matcher gwm_checker u_gwm_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tuser  (req_tuser),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

// ===== tb/tb_glob_wildcard_matcher.sv =====
// testbench for the glob wildcard matcher: stream driver, pattern predictor and scoreboard
`timescale 1ns / 1ps

module tb_glob_wildcard_matcher;

   localparam int PLEN = 64;
   localparam int STALL_LIMIT = 5000;

   // outcome of one end-of-subject beat
   typedef struct packed {
      logic too_long;
      logic matched;
   } match_result_type;

   // glob predictor and queue of pending match results
   class match_scoreboard_type;
      logic [7:0] pat[PLEN];
      int unsigned pat_len;
      bit live[PLEN+1];
      bit overflow;
      match_result_type pending[$];
      int unsigned errors;

      function new();
         pat_len = 0;
         overflow = 0;
         errors = 0;
         restart();
      endfunction

      function void restart();
         foreach (live[i]) live[i] = 0;
         live[0] = 1;
      endfunction

      function int unsigned pat_char(int unsigned k);
         return (k < pat_len) ? pat[k] : 0;
      endfunction

      function void close_stars();
         for (int unsigned i = 0; i < pat_len; i++)
            if (live[i] && pat[i] == gwm_pkg::CH_STAR) live[i+1] = 1;
      endfunction

      // returns -1 unterminated, else 1 or 0; nxt gets index after the close
      function int class_hit(int unsigned lb, int unsigned b, output int unsigned nxt);
         int unsigned p, lo, hi;
         bit neg, hit;
         p = lb + 1;
         neg = (pat_char(p) == gwm_pkg::CH_CARET);
         hit = 0;
         if (neg) p++;
         forever begin
            if (p >= pat_len) return -1;
            lo = pat_char(p);
            if (pat_char(p+1) == gwm_pkg::CH_DASH && pat_char(p+2) != gwm_pkg::CH_CLOSE) begin
               hi = pat_char(p+2);
               p++;
            end else begin
               hi = lo;
            end
            if (lo == b || (lo <= b && b <= hi)) hit = 1;
            p++;
            if (pat_char(p) == gwm_pkg::CH_CLOSE) break;
         end
         nxt = p + 1;
         return (hit != neg) ? 1 : 0;
      endfunction

      function void take(int unsigned b);
         bit nxt_live[PLEN+1];
         int unsigned nx;
         foreach (nxt_live[i]) nxt_live[i] = 0;
         close_stars();
         for (int unsigned i = 0; i < pat_len; i++) begin
            if (!live[i]) continue;
            if (pat[i] == gwm_pkg::CH_STAR) nxt_live[i] = 1;
            else if (pat[i] == gwm_pkg::CH_QUERY) nxt_live[i+1] = 1;
            else if (pat[i] == gwm_pkg::CH_OPEN) begin
               if (class_hit(i, b, nx) == 1 && nx <= pat_len) nxt_live[nx] = 1;
            end else if (pat[i] == b) nxt_live[i+1] = 1;
         end
         live = nxt_live;
      endfunction

      // note one accepted input beat
      function void note_input(logic [1:0] kind, logic [7:0] pb, logic [7:0] sb);
         match_result_type r;
         case (kind)
            gwm_pkg::KIND_CLEAR: begin
               pat_len = 0;
               overflow = 0;
               restart();
            end
            gwm_pkg::KIND_APPEND: begin
               if (pb != 0) begin
                  if (pat_len < PLEN) begin
                     pat[pat_len] = pb;
                     pat_len++;
                  end else begin
                     overflow = 1;
                  end
               end
               restart();
            end
            gwm_pkg::KIND_SUBJECT: take(sb);
            default: begin
               close_stars();
               r.matched = live[pat_len] && !overflow;
               r.too_long = overflow;
               pending.push_back(r);
               restart();
            end
         endcase
      endfunction

      // check one accepted result beat
      function void check_result(logic [7:0] data);
         match_result_type e;
         if (pending.size() == 0) begin
            errors++;
            if (errors <= 10) $display("unexpected result beat %h", data);
            return;
         end
         e = pending.pop_front();
         if (data[0] !== e.matched || data[1] !== e.too_long || data[7:2] !== 6'd0) begin
            errors++;
            if (errors <= 10)
               $display("result mismatch: expected matched=%0b too_long=%0b, got %h",
                        e.matched, e.too_long, data);
         end
      endfunction
   endclass

   logic clock = 0;
   logic reset = 1;
   logic req_tvalid = 0;
   logic req_tready;
   logic [15:0] req_tdata = 0;
   logic [1:0] req_tuser = 0;
   logic rsp_tvalid;
   logic rsp_tready = 0;
   logic [7:0] rsp_tdata;

   int unsigned send_idle_pct = 0;
   int unsigned recv_idle_pct = 0;
   bit hold_off = 0;
   int unsigned quiet_cycles = 0;
   match_scoreboard_type sb = new();

   always #5 clock = ~clock;

   glob_wildcard_matcher #(.PAT_LEN(PLEN)) dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
   );

   // monitor both channels and run the watchdog
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) sb.note_input(req_tuser, req_tdata[7:0], req_tdata[15:8]);
         if (rsp_tvalid && rsp_tready) sb.check_result(rsp_tdata);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) quiet_cycles <= 0;
         else quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles > STALL_LIMIT) begin
            $display("tb_glob_wildcard_matcher NOT OK");
            $finish;
         end
      end
   end

   // receiver ready with random stalls and forced hold-off
   always @(posedge clock) begin
      if (reset) rsp_tready <= 0;
      else rsp_tready <= !hold_off && ($urandom_range(99) >= recv_idle_pct);
   end

   function automatic logic [7:0] rand_byte();
      return 8'($urandom_range(255));
   endfunction

   // send one input beat with random idle gaps
   task automatic send_beat(logic [1:0] kind, logic [7:0] pb, logic [7:0] subj);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 0;
         @(posedge clock);
      end
      req_tvalid <= 1;
      req_tuser <= kind;
      req_tdata <= {subj, pb};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   task automatic load_pattern(string s);
      send_beat(gwm_pkg::KIND_CLEAR, rand_byte(), rand_byte());
      foreach (s[i]) send_beat(gwm_pkg::KIND_APPEND, s[i], rand_byte());
   endtask

   task automatic run_subject(string s);
      foreach (s[i]) send_beat(gwm_pkg::KIND_SUBJECT, rand_byte(), s[i]);
      send_beat(gwm_pkg::KIND_END, rand_byte(), rand_byte());
   endtask

   function automatic logic [7:0] rand_pat_char();
      case ($urandom_range(9))
         0: return gwm_pkg::CH_STAR;
         1: return gwm_pkg::CH_QUERY;
         2: return gwm_pkg::CH_OPEN;
         3: return gwm_pkg::CH_CLOSE;
         4: return gwm_pkg::CH_DASH;
         5: return gwm_pkg::CH_CARET;
         6: return 8'($urandom_range(1, 255));
         default: return 8'("a" + $urandom_range(3));
      endcase
   endfunction

   function automatic logic [7:0] rand_subj_char();
      case ($urandom_range(5))
         0: return 8'($urandom_range(0, 255));
         1: return gwm_pkg::CH_CLOSE;
         default: return 8'("a" + $urandom_range(4));
      endcase
   endfunction

   // random pattern followed by a few subjects
   task automatic random_group();
      int unsigned plen, slen;
      plen = ($urandom_range(30) == 0) ? $urandom_range(60, 70) : $urandom_range(0, 8);
      send_beat(gwm_pkg::KIND_CLEAR, 8'h00, 8'h00);
      for (int i = 0; i < plen; i++) begin
         if ($urandom_range(40) == 0) send_beat(gwm_pkg::KIND_APPEND, 8'h00, rand_byte());
         else send_beat(gwm_pkg::KIND_APPEND, rand_pat_char(), rand_byte());
      end
      repeat ($urandom_range(1, 4)) begin
         slen = $urandom_range(0, 7);
         for (int i = 0; i < slen; i++)
            send_beat(gwm_pkg::KIND_SUBJECT, rand_byte(), rand_subj_char());
         if ($urandom_range(15) == 0) send_beat(gwm_pkg::KIND_APPEND, rand_pat_char(), 8'h00);
         send_beat(gwm_pkg::KIND_END, rand_byte(), rand_byte());
      end
   endtask

   // long receiver hold-off while the sender keeps offering
   initial begin
      wait (!reset);
      repeat (300) @(posedge clock);
      hold_off <= 1;
      repeat (200) @(posedge clock);
      hold_off <= 0;
   end

   initial begin
      int unsigned drain;
      string text;
      repeat (4) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: extremes, every element and special cases
      load_pattern("a*[^]x-z]?");
      run_subject("abc]q");
      text = "abxw";
      text.putc(2, 8'hFF);
      run_subject(text);
      load_pattern("[]-a-c-]");
      run_subject("b");
      run_subject("-");
      load_pattern("[abc");
      run_subject("a");
      load_pattern("*[a");
      run_subject("");
      load_pattern("?");
      send_beat(gwm_pkg::KIND_SUBJECT, 8'h00, 8'h00);
      send_beat(gwm_pkg::KIND_END, 8'hFF, 8'hFF);
      send_beat(gwm_pkg::KIND_APPEND, 8'hFF, 8'h00);
      text = "x";
      text.putc(0, 8'hFF);
      run_subject(text);

      for (int ph = 0; ph < 3; ph++) begin
         send_idle_pct = (ph == 0) ? 23 : (ph == 1) ? 86 : 0;
         recv_idle_pct = (ph == 0) ? 86 : (ph == 1) ? 23 : 0;
         for (int g = 0; g < 36; g++) random_group();
      end
      req_tvalid <= 0;

      drain = 0;
      while (sb.pending.size() != 0 && drain < 20000) begin
         @(posedge clock);
         drain++;
      end
      repeat (10) @(posedge clock);
      if (sb.errors == 0 && sb.pending.size() == 0) $display("tb_glob_wildcard_matcher OK");
      else $display("tb_glob_wildcard_matcher NOT OK");
      $finish;
   end

endmodule
